### design/iou_pkg.sv
`default_nettype none

package iou_pkg;

    // Side flags that travel with an item through the divider
    typedef struct packed {
        logic degenerate;  // union area zero or negative
        logic saturate;    // intersection not below union
    } iou_flag_t;

endpackage

`default_nettype wire

### design/iou_frac_div.sv
`default_nettype none

module iou_frac_div
    import iou_pkg::*;
#(
    parameter int NUM_BITS  = 34,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [NUM_BITS-1:0]  num,
    input  wire logic [NUM_BITS-1:0]  den,
    input  wire iou_flag_t            flags,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [FRAC_BITS:0]        ratio,
    output logic                      degenerate
);

    localparam logic [FRAC_BITS:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // One quotient bit per stage
    logic [NUM_BITS-1:0]  rem_reg  [FRAC_BITS];
    logic [NUM_BITS-1:0]  den_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg    [FRAC_BITS];
    iou_flag_t            flag_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] valid_reg;
    logic [FRAC_BITS-1:0] stage_ready;

    logic                 out_valid_reg;
    logic [FRAC_BITS:0]   ratio_reg;
    logic                 degenerate_reg;
    logic                 out_stage_ready;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign in_ready        = stage_ready[0];

    genvar i;
    generate
        for (i = 0; i < FRAC_BITS; i++) begin : g_stage
            logic [NUM_BITS-1:0]  rem_src;
            logic [NUM_BITS-1:0]  den_src;
            logic [FRAC_BITS-1:0] q_src;
            iou_flag_t            flag_src;
            logic                 valid_src;
            logic                 next_ready;
            logic [NUM_BITS:0]    rem_shift;
            logic [NUM_BITS:0]    rem_sub;
            logic                 take;

            // Select the previous stage or the block input
            if (i == 0) begin : g_first
                assign rem_src   = num;
                assign den_src   = den;
                assign q_src     = '0;
                assign flag_src  = flags;
                assign valid_src = in_valid;
            end
            else begin : g_inner
                assign rem_src   = rem_reg[i-1];
                assign den_src   = den_reg[i-1];
                assign q_src     = q_reg[i-1];
                assign flag_src  = flag_reg[i-1];
                assign valid_src = valid_reg[i-1];
            end

            if (i == FRAC_BITS - 1) begin : g_last
                assign next_ready = out_stage_ready;
            end
            else begin : g_mid
                assign next_ready = stage_ready[i+1];
            end

            assign stage_ready[i] = !valid_reg[i] || next_ready;

            // Restoring step: shift, trial subtract, keep if non-negative
            assign rem_shift = {rem_src, 1'b0};
            assign rem_sub   = rem_shift - {1'b0, den_src};
            assign take      = rem_shift >= {1'b0, den_src};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[i])
                begin
                    rem_reg[i]  <= take ? rem_sub[NUM_BITS-1:0] : rem_shift[NUM_BITS-1:0];
                    den_reg[i]  <= den_src;
                    q_reg[i]    <= {q_src[FRAC_BITS-2:0], take};
                    flag_reg[i] <= flag_src;
                end
            end
        end
    endgenerate

    // Output register: apply the degenerate and saturated cases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid_reg <= valid_reg[FRAC_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready)
        begin
            degenerate_reg <= flag_reg[FRAC_BITS-1].degenerate;
            if (flag_reg[FRAC_BITS-1].degenerate)
            begin
                ratio_reg <= '0;
            end
            else if (flag_reg[FRAC_BITS-1].saturate)
            begin
                ratio_reg <= RATIO_ONE;
            end
            else
            begin
                ratio_reg <= {1'b0, q_reg[FRAC_BITS-1]};
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ratio      = ratio_reg;
    assign degenerate = degenerate_reg;

endmodule

`default_nettype wire

### design/box_intersection_over_union.sv
// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// input   | in_valid, in_ready, box_a_*, box_b_*      | into block
// output  | out_valid, out_ready, overlap_ratio,      | out of block
//         | degenerate                                |
//
// One box pair per cycle sustained while out_ready stays high. The pipe is five
// stages of min/max, clamp, area multiply, union sum and compare, then one
// restoring-division stage per quotient bit and an output register. Reset
// clears all valid bits only. Each stage holds while its successor is full
// and stalled; empty stages keep filling.
`default_nettype none

module box_intersection_over_union
    import iou_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] box_a_left,
    input  wire logic signed [COORD_BITS-1:0] box_a_top,
    input  wire logic signed [COORD_BITS-1:0] box_a_right,
    input  wire logic signed [COORD_BITS-1:0] box_a_bottom,
    input  wire logic signed [COORD_BITS-1:0] box_b_left,
    input  wire logic signed [COORD_BITS-1:0] box_b_top,
    input  wire logic signed [COORD_BITS-1:0] box_b_right,
    input  wire logic signed [COORD_BITS-1:0] box_b_bottom,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [RATIO_FRAC_BITS:0]          overlap_ratio,
    output logic                              degenerate
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;       // signed side length
    localparam int PW = 2 * COORD_BITS + 2;   // signed box area
    localparam int UW = 2 * COORD_BITS + 3;   // signed union
    localparam int NW = 2 * COORD_BITS + 2;   // divider operands

    // Stage 1: intersection corners and box sides
    logic                 s1_valid_reg;
    logic                 s1_ready;
    logic signed [CW-1:0] s1_il_reg, s1_it_reg, s1_ir_reg, s1_ib_reg;
    logic signed [DW-1:0] s1_aw_reg, s1_ah_reg, s1_bw_reg, s1_bh_reg;

    // Stage 2: clamped intersection sides
    logic                 s2_valid_reg;
    logic                 s2_ready;
    logic [CW-1:0]        s2_iw_reg, s2_ih_reg;
    logic signed [DW-1:0] s2_aw_reg, s2_ah_reg, s2_bw_reg, s2_bh_reg;
    logic signed [DW-1:0] s2_iw_diff, s2_ih_diff;

    // Stage 3: areas
    logic                 s3_valid_reg;
    logic                 s3_ready;
    logic [2*CW-1:0]      s3_inter_reg;
    logic signed [PW-1:0] s3_area_a_reg, s3_area_b_reg;

    // Stage 4: union
    logic                 s4_valid_reg;
    logic                 s4_ready;
    logic [2*CW-1:0]      s4_inter_reg;
    logic signed [UW-1:0] s4_uni_next, s4_uni_reg;

    // Stage 5: special cases and divider operands
    logic                 s5_valid_reg;
    logic                 s5_ready;
    logic [NW-1:0]        s5_num_reg, s5_den_reg;
    iou_flag_t            s5_flag_next, s5_flag_reg;

    logic                 div_in_ready;

    assign s5_ready = !s5_valid_reg || div_in_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage 1: larger top-left, smaller bottom-right, signed box sides
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_il_reg <= (box_a_left > box_b_left) ? box_a_left : box_b_left;
            s1_it_reg <= (box_a_top > box_b_top) ? box_a_top : box_b_top;
            s1_ir_reg <= (box_a_right < box_b_right) ? box_a_right : box_b_right;
            s1_ib_reg <= (box_a_bottom < box_b_bottom) ? box_a_bottom : box_b_bottom;
            s1_aw_reg <= DW'(box_a_right) - DW'(box_a_left);
            s1_ah_reg <= DW'(box_a_bottom) - DW'(box_a_top);
            s1_bw_reg <= DW'(box_b_right) - DW'(box_b_left);
            s1_bh_reg <= DW'(box_b_bottom) - DW'(box_b_top);
        end
    end

    // Stage 2: clamp intersection sides at zero
    assign s2_iw_diff = DW'(s1_ir_reg) - DW'(s1_il_reg);
    assign s2_ih_diff = DW'(s1_ib_reg) - DW'(s1_it_reg);

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_iw_reg <= (s1_ir_reg > s1_il_reg) ? s2_iw_diff[CW-1:0] : '0;
            s2_ih_reg <= (s1_ib_reg > s1_it_reg) ? s2_ih_diff[CW-1:0] : '0;
            s2_aw_reg <= s1_aw_reg;
            s2_ah_reg <= s1_ah_reg;
            s2_bw_reg <= s1_bw_reg;
            s2_bh_reg <= s1_bh_reg;
        end
    end

    // Stage 3: intersection and signed box areas
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_inter_reg  <= (2*CW)'(s2_iw_reg) * (2*CW)'(s2_ih_reg);
            s3_area_a_reg <= PW'(s2_aw_reg) * PW'(s2_ah_reg);
            s3_area_b_reg <= PW'(s2_bw_reg) * PW'(s2_bh_reg);
        end
    end

    // Stage 4: union = area A + area B - intersection
    assign s4_uni_next = UW'(s3_area_a_reg) + UW'(s3_area_b_reg) - UW'(s3_inter_reg);

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_inter_reg <= s3_inter_reg;
            s4_uni_reg   <= s4_uni_next;
        end
    end

    // Stage 5: flag empty or negative union and full overlap
    always_comb
    begin
        s5_flag_next.degenerate = s4_uni_reg[UW-1] || (s4_uni_reg == '0);
        s5_flag_next.saturate   = !s5_flag_next.degenerate
                                  && (UW'(s4_inter_reg) >= $unsigned(s4_uni_reg));
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            s5_num_reg  <= NW'(s4_inter_reg);
            s5_den_reg  <= s4_uni_reg[NW-1:0];
            s5_flag_reg <= s5_flag_next;
        end
    end

    // Fraction divider and output register
    iou_frac_div #(
        .NUM_BITS  (NW),
        .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_frac_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s5_valid_reg),
        .in_ready   (div_in_ready),
        .num        (s5_num_reg),
        .den        (s5_den_reg),
        .flags      (s5_flag_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ratio      (overlap_ratio),
        .degenerate (degenerate)
    );

endmodule

`default_nettype wire

### design/iou_checker.sv
`default_nettype none

module iou_checker
#(
    parameter int RATIO_FRAC_BITS = 16
)
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [RATIO_FRAC_BITS:0]   overlap_ratio,
    input wire logic                       degenerate
);

    localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlap_ratio) && $stable(degenerate))
        else $error("result changed while stalled");

    // Degenerate union reports a zero ratio
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> overlap_ratio == '0)
        else $error("degenerate result with nonzero ratio");

    // Ratio never exceeds one
    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> overlap_ratio <= RATIO_ONE)
        else $error("ratio above one");

    // An empty output register lets the whole pipeline advance
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Nothing leaves the block in the cycle after reset releases
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

endmodule

bind box_intersection_over_union iou_checker #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_iou_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .overlap_ratio (overlap_ratio),
    .degenerate    (degenerate)
);

`default_nettype wire

### test/tb_box_intersection_over_union.sv
module tb_box_intersection_over_union;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int N_RANDOM     = 630;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 120;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 420;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t a_left;
        coord_t a_top;
        coord_t a_right;
        coord_t a_bottom;
        coord_t b_left;
        coord_t b_top;
        coord_t b_right;
        coord_t b_bottom;
    } box_pair_t;

    typedef struct packed {
        logic [FRAC_BITS:0] ratio;
        logic               degenerate;
    } overlap_t;

    typedef struct packed {
        box_pair_t pair;
        overlap_t  result;
    } pending_overlap_t;

    // Predict the overlap ratio of each accepted pair and compare in order
    class overlap_scoreboard;
        pending_overlap_t pending_overlaps[$];
        int unsigned      mismatches;
        int unsigned      accepted;

        function overlap_t predict_overlap(box_pair_t p);
            longint   al, at, ar, ab, bl, bt, br, bb;
            longint   cut_l, cut_t, cut_r, cut_b, cut_w, cut_h;
            longint   inter_area, area_a, area_b, union_area;
            longint   rem, quot;
            overlap_t res;
            al = $signed(p.a_left);
            at = $signed(p.a_top);
            ar = $signed(p.a_right);
            ab = $signed(p.a_bottom);
            bl = $signed(p.b_left);
            bt = $signed(p.b_top);
            br = $signed(p.b_right);
            bb = $signed(p.b_bottom);
            // Intersection: larger top-left, smaller bottom-right, clamp at zero
            cut_l = (al > bl) ? al : bl;
            cut_t = (at > bt) ? at : bt;
            cut_r = (ar < br) ? ar : br;
            cut_b = (ab < bb) ? ab : bb;
            cut_w = (cut_r > cut_l) ? cut_r - cut_l : 0;
            cut_h = (cut_b > cut_t) ? cut_b - cut_t : 0;
            inter_area = cut_w * cut_h;
            // Box areas keep their sign when a box is inverted
            area_a     = (ar - al) * (ab - at);
            area_b     = (br - bl) * (bb - bt);
            union_area = area_a + area_b - inter_area;
            res.ratio      = '0;
            res.degenerate = 1'b0;
            if (union_area <= 0) begin
                res.degenerate = 1'b1;
            end
            else if (inter_area >= union_area) begin
                res.ratio = {1'b1, {FRAC_BITS{1'b0}}};
            end
            else begin
                // Restoring division, one quotient bit per step, truncated
                rem  = inter_area;
                quot = 0;
                for (int i = 0; i < FRAC_BITS; i++) begin
                    rem  = rem << 1;
                    quot = quot << 1;
                    if (rem >= union_area) begin
                        rem  = rem - union_area;
                        quot = quot | 1;
                    end
                end
                res.ratio = quot[FRAC_BITS:0];
            end
            return res;
        endfunction

        function void note_pair(box_pair_t p);
            pending_overlap_t entry;
            entry.pair   = p;
            entry.result = predict_overlap(p);
            pending_overlaps.push_back(entry);
            accepted++;
        endfunction

        function void check_result(overlap_t got);
            pending_overlap_t entry;
            if (pending_overlaps.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with nothing pending: ratio %0d degenerate %0b",
                             got.ratio, got.degenerate);
                return;
            end
            entry = pending_overlaps.pop_front();
            if (got.ratio !== entry.result.ratio
                    || got.degenerate !== entry.result.degenerate) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: A (%0d,%0d)-(%0d,%0d) B (%0d,%0d)-(%0d,%0d)",
                             entry.pair.a_left, entry.pair.a_top,
                             entry.pair.a_right, entry.pair.a_bottom,
                             entry.pair.b_left, entry.pair.b_top,
                             entry.pair.b_right, entry.pair.b_bottom);
                    $display("       ratio exp %0d got %0d, degenerate exp %0b got %0b",
                             entry.result.ratio, got.ratio,
                             entry.result.degenerate, got.degenerate);
                end
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    box_pair_t          offered   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [FRAC_BITS:0] overlap_ratio;
    logic               degenerate;
    bit                 calm      = 1'b0;

    overlap_scoreboard sb = new();

    box_intersection_over_union #(
        .COORD_BITS      (COORD_BITS),
        .RATIO_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .box_a_left    (offered.a_left),
        .box_a_top     (offered.a_top),
        .box_a_right   (offered.a_right),
        .box_a_bottom  (offered.a_bottom),
        .box_b_left    (offered.b_left),
        .box_b_top     (offered.b_top),
        .box_b_right   (offered.b_right),
        .box_b_bottom  (offered.b_bottom),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .overlap_ratio (overlap_ratio),
        .degenerate    (degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record each input transfer and check each output transfer at the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_pair(offered);
        if (rst_n && out_valid && out_ready)
            sb.check_result({overlap_ratio, degenerate});
    end

    function automatic box_pair_t pair_of(int al, int at, int ar, int ab,
                                          int bl, int bt, int br, int bb);
        box_pair_t p;
        p.a_left   = coord_t'(al);
        p.a_top    = coord_t'(at);
        p.a_right  = coord_t'(ar);
        p.a_bottom = coord_t'(ab);
        p.b_left   = coord_t'(bl);
        p.b_top    = coord_t'(bt);
        p.b_right  = coord_t'(br);
        p.b_bottom = coord_t'(bb);
        return p;
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(128)) - 64;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Mostly overlapping well-formed boxes, plus raw, small, extreme and equal pairs
    function automatic box_pair_t random_pair();
        int        kind, al, at, aw, ah, bl, bt, bw, bh, span;
        box_pair_t p;
        kind = $urandom_range(99);
        span = $urandom_range(1) ? 64 : 4000;
        al   = int'($urandom_range(40000)) - 20000;
        at   = int'($urandom_range(40000)) - 20000;
        aw   = int'($urandom_range(1, span));
        ah   = int'($urandom_range(1, span));
        bw   = int'($urandom_range(1, span));
        bh   = int'($urandom_range(1, span));
        bl   = al + int'($urandom_range(2 * aw)) - aw;
        bt   = at + int'($urandom_range(2 * ah)) - ah;
        if (kind < 60)
            p = pair_of(al, at, al + aw, at + ah, bl, bt, bl + bw, bt + bh);
        else if (kind < 78)
            p = {$urandom(), $urandom(), $urandom(), $urandom()};
        else if (kind < 88)
            p = pair_of(small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord(), small_coord(), small_coord(), small_coord());
        else if (kind < 94)
            p = pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                        extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
        else
            p = pair_of(al, at, al + aw, at + ah, al, at, al + aw, at + ah);
        return p;
    endfunction

    // Offer one pair, idling first at random, and hold it until the transfer
    task automatic offer_pair(input box_pair_t pair);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        offered  <= pair;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Accept results with random stalls; hold off once long enough to fill the pipe
    initial
    begin : receiver
        int unsigned held_cycles;
        bit          held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever begin
            if (!held_off && sb.accepted >= HOLD_AFTER) begin
                held_off  = 1'b1;
                out_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(posedge clk);
            end
            else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        box_pair_t directed[$];
        // Equal boxes saturate, disjoint and touching boxes give zero; partial and nested overlaps follow
        directed.push_back(pair_of(0, 0, 160, 160, 0, 0, 160, 160));
        directed.push_back(pair_of(0, 0, 16, 16, 32, 32, 48, 48));
        directed.push_back(pair_of(0, 0, 16, 16, 16, 0, 32, 16));
        directed.push_back(pair_of(0, 0, 32, 32, 16, 16, 48, 48));
        directed.push_back(pair_of(0, 0, 64, 64, 16, 16, 32, 32));
        directed.push_back(pair_of(16, 16, 32, 32, 0, 0, 64, 64));
        directed.push_back(pair_of(0, 16, 64, 32, 16, 0, 32, 64));
        directed.push_back(pair_of(-64, -64, 16, 16, -16, -32, 48, 80));
        directed.push_back(pair_of(0, 0, 1000, 1000, 0, 0, 1000, 999));
        // Zero-area boxes: points and lines
        directed.push_back(pair_of(5, 5, 5, 5, 5, 5, 5, 5));
        directed.push_back(pair_of(0, 0, 0, 100, 0, 0, 0, 100));
        directed.push_back(pair_of(0, 0, 0, 0, 0, 0, 16, 16));
        // Inverted boxes: negative area, cancelling areas, doubly inverted
        directed.push_back(pair_of(100, 0, -100, 100, 0, 0, 16, 16));
        directed.push_back(pair_of(32, 0, 0, 8, 0, 0, 16, 16));
        directed.push_back(pair_of(16, 16, 0, 0, 0, 0, 16, 16));
        // Coordinate extremes
        directed.push_back(pair_of(-32768, -32768, 32767, 32767,
                                   -32768, -32768, 32767, 32767));
        directed.push_back(pair_of(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        directed.push_back(pair_of(-32768, -32768, 32767, 32767,
                                   -32768, -32768, 0, 32767));
        directed.push_back(pair_of(32767, 32767, -32768, -32768,
                                   32767, 32767, -32768, -32768));
        directed.push_back(pair_of(32767, -32768, -32768, 32767, 0, 0, 16, 16));
        directed.push_back(pair_of(32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768, -32768));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer_pair(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            offer_pair(random_pair());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain the pipe, then allow stray results to show up
        while (sb.pending_overlaps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("ERROR: timeout with %0d results pending", sb.pending_overlaps.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
design/iou_pkg.sv
design/iou_frac_div.sv
design/box_intersection_over_union.sv
design/iou_checker.sv
test/tb_box_intersection_over_union.sv
